// File: sv/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock: key codes, event codes,
// the lock phase and the result word.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Key codes
    localparam logic [7:0] KEY_NONE   = 8'hFF;
    localparam logic [7:0] KEY_LOGIN  = 8'h31;
    localparam logic [7:0] KEY_CHANGE = 8'h32;

    // Saturation value of the failed-attempt counter and reset value of the failed-login limit
    localparam logic [2:0] ATTEMPT_SAT  = 3'd7;
    localparam logic [2:0] ATTEMPT_RST  = 3'd3;

    // Event codes reported with every word
    typedef enum logic [3:0] {
        EV_TAKEN       = 4'd0,
        EV_SAVED       = 4'd1,
        EV_BAD_CHOICE  = 4'd2,
        EV_WRONG       = 4'd3,
        EV_LOCKED      = 4'd4,
        EV_GRANTED     = 4'd5,
        EV_CUR_WRONG   = 4'd6,
        EV_MISMATCH    = 4'd7,
        EV_UPDATED     = 4'd8,
        EV_IGNORED     = 4'd9
    } t_event;

    // Lock phase, one-hot
    typedef enum logic [7:0] {
        M_SETUP   = 8'b0000_0001,
        M_MENU    = 8'b0000_0010,
        M_LOGIN   = 8'b0000_0100,
        M_CHG_CUR = 8'b0000_1000,
        M_CHG_NEW = 8'b0001_0000,
        M_CHG_RE  = 8'b0010_0000,
        M_GRANTED = 8'b0100_0000,
        M_LOCKED  = 8'b1000_0000
    } t_mode;

    // Result word
    typedef struct packed {
        t_event     event_res;
        logic       door_open;
        logic       locked;
        logic [2:0] digits_entered;
    } t_result;

endpackage

// File: sv/kcl_key_if.sv
// ----------------------------------------------------------------------------
// kcl_key_if
// Key channel: valid/ready handshake carrying one keypad code per word.
// ----------------------------------------------------------------------------
interface kcl_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

// File: sv/kcl_res_if.sv
// ----------------------------------------------------------------------------
// kcl_res_if
// Result channel: valid/ready handshake carrying one lock event per word.
// ----------------------------------------------------------------------------
interface kcl_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic       door_open;
    logic       locked;
    logic [2:0] digits_entered;

    modport source (output valid, output event_res, output door_open,
                    output locked, output digits_entered, input ready);
    modport sink   (input valid, input event_res, input door_open,
                    input locked, input digits_entered, output ready);
endinterface

// File: sv/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad combination lock: first code setup, login with attempt limit and
// lockout, and code change with double entry of the new code.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_key     in   valid/ready    key[7:0]
//  o_res     out  valid/ready    event_res[3:0] door_open locked digits_entered[2:0]
//  i_cfg     in   write enable   i_cfg_wdata[2:0] = failed-login limit
//
// One key word per cycle while i_key.ready is high; its result is registered into the output queue.
// The whole update (phase step, digit store, parallel code compare) sits
// between the key handshake and a two-word output queue.
// A stalled output keeps up to two results; i_key.ready drops only when both
// are occupied. Reset (synchronous, active low) returns to first code setup
// with a failed-login limit of 3; code buffers are not cleared.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
    parameter int CODE_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kcl_key_if.sink     i_key,
    kcl_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);

    localparam int CW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(CODE_DIGITS - 1);

    // State
    kcl_pkg::t_mode   r_mode, n_mode;
    logic [CW-1:0]    r_count, n_count;
    logic [2:0]       r_att, n_att;
    logic [2:0]       r_max;
    logic [7:0]       r_entry  [CODE_DIGITS];
    logic [7:0]       r_stored [CODE_DIGITS];
    logic [7:0]       r_new    [CODE_DIGITS];

    // Output queue: head and skid word
    kcl_pkg::t_result r_head, r_skid, res;
    logic             r_head_valid, r_skid_valid;

    logic             accept, fire;
    logic             is_none, last, match_stored, match_new;
    logic             wr_entry, wr_new, cp_entry, cp_new;
    logic [7:0]       cand [CODE_DIGITS];
    logic [CW+2:0]    cnt_wide;
    kcl_pkg::t_event  ev;

    assign accept = i_key.valid & i_key.ready;
    assign fire   = r_head_valid & o_res.ready;
    assign i_key.ready = ~r_skid_valid;

    assign is_none = (i_key.key == kcl_pkg::KEY_NONE);
    assign last    = (r_count == LAST_IDX);

    // Build the entry as it stands with this key put in place
    always_comb begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
            cand[i] = (r_count == CW'(i)) ? i_key.key : r_entry[i];
        end
    end

    // Parallel compares of the completed entry
    always_comb begin
        match_stored = 1'b1;
        match_new    = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (cand[i] != r_stored[i]) match_stored = 1'b0;
            if (cand[i] != r_new[i])    match_new    = 1'b0;
        end
    end

    // Phase step for one key
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_att    = r_att;
        ev       = kcl_pkg::EV_TAKEN;
        wr_entry = 1'b0;
        wr_new   = 1'b0;
        cp_entry = 1'b0;
        cp_new   = 1'b0;
        if (is_none) begin
            ev = kcl_pkg::EV_IGNORED;
        end else begin
            case (r_mode)
                kcl_pkg::M_SETUP: begin
                    wr_entry = 1'b1;
                    n_count  = last ? '0 : r_count + 1'b1;
                    if (last) begin
                        cp_entry = 1'b1;
                        n_mode   = kcl_pkg::M_MENU;
                        ev       = kcl_pkg::EV_SAVED;
                    end
                end
                kcl_pkg::M_MENU: begin
                    n_count = '0;
                    if (i_key.key == kcl_pkg::KEY_LOGIN) begin
                        n_mode = kcl_pkg::M_LOGIN;
                    end else if (i_key.key == kcl_pkg::KEY_CHANGE) begin
                        n_mode = kcl_pkg::M_CHG_CUR;
                    end else begin
                        ev = kcl_pkg::EV_BAD_CHOICE;
                    end
                end
                kcl_pkg::M_LOGIN: begin
                    wr_entry = 1'b1;
                    n_count  = last ? '0 : r_count + 1'b1;
                    if (last) begin
                        if (match_stored) begin
                            n_mode = kcl_pkg::M_GRANTED;
                            ev     = kcl_pkg::EV_GRANTED;
                        end else begin
                            n_att = (r_att < kcl_pkg::ATTEMPT_SAT) ? r_att + 1'b1 : r_att;
                            if (n_att >= r_max) begin
                                n_mode = kcl_pkg::M_LOCKED;
                                ev     = kcl_pkg::EV_LOCKED;
                            end else begin
                                ev = kcl_pkg::EV_WRONG;
                            end
                        end
                    end
                end
                kcl_pkg::M_CHG_CUR: begin
                    wr_entry = 1'b1;
                    n_count  = last ? '0 : r_count + 1'b1;
                    if (last) begin
                        if (match_stored) begin
                            n_mode = kcl_pkg::M_CHG_NEW;
                        end else begin
                            n_mode = kcl_pkg::M_MENU;
                            ev     = kcl_pkg::EV_CUR_WRONG;
                        end
                    end
                end
                kcl_pkg::M_CHG_NEW: begin
                    wr_new  = 1'b1;
                    n_count = last ? '0 : r_count + 1'b1;
                    if (last) n_mode = kcl_pkg::M_CHG_RE;
                end
                kcl_pkg::M_CHG_RE: begin
                    wr_entry = 1'b1;
                    n_count  = last ? '0 : r_count + 1'b1;
                    if (last) begin
                        n_mode = kcl_pkg::M_MENU;
                        if (match_new) begin
                            cp_new = 1'b1;
                            ev     = kcl_pkg::EV_UPDATED;
                        end else begin
                            ev = kcl_pkg::EV_MISMATCH;
                        end
                    end
                end
                kcl_pkg::M_GRANTED: begin
                    ev = kcl_pkg::EV_IGNORED;
                end
                default: begin
                    n_mode = kcl_pkg::M_LOCKED;
                    ev     = kcl_pkg::EV_LOCKED;
                end
            endcase
        end
    end

    // Form the result word
    assign cnt_wide = {3'b000, n_count};
    always_comb begin
        res.event_res      = ev;
        res.door_open      = (n_mode == kcl_pkg::M_GRANTED);
        res.locked         = (n_mode == kcl_pkg::M_LOCKED);
        res.digits_entered = cnt_wide[2:0];
    end

    // Advance control state on an accepted word; take config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= kcl_pkg::M_SETUP;
            r_count <= '0;
            r_att   <= '0;
            r_max   <= kcl_pkg::ATTEMPT_RST;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_att   <= n_att;
            end
            if (i_cfg_we) r_max <= i_cfg_wdata;
        end
    end

    // Code buffers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
                if (wr_entry) r_entry[i] <= cand[i];
                if (wr_new && r_count == CW'(i)) r_new[i] <= i_key.key;
                if (cp_entry) r_stored[i] <= cand[i];
                else if (cp_new) r_stored[i] <= r_new[i];
            end
        end
    end

    // Output queue: refill head from skid or from the new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_head_valid || fire) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= accept;
            end else begin
                r_head_valid <= accept;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the queue, no reset
    always_ff @(posedge i_clk) begin
        if (!r_head_valid || fire) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                r_skid <= res;
            end else begin
                r_head <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_res.valid          = r_head_valid;
    assign o_res.event_res      = r_head.event_res;
    assign o_res.door_open      = r_head.door_open;
    assign o_res.locked         = r_head.locked;
    assign o_res.digits_entered = r_head.digits_entered;

    // Lockout is permanent until reset
    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == kcl_pkg::M_LOCKED |=> r_mode == kcl_pkg::M_LOCKED)
        else $error("lockout left without reset");

    // Granted access is permanent until reset
    a_grant_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == kcl_pkg::M_GRANTED |=> r_mode == kcl_pkg::M_GRANTED)
        else $error("granted state left without reset");

    // Skid word only exists behind a head word
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid word without head word");

    // Digit index stays inside the code length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("digit index out of range");

endmodule
